[sv/plfl_pkg.sv]
// Package for the pulse run-length frame logger: sizes, register indexes,
// saturation limits and the structs passed between the front, queue and back.
// No dependencies.
package plfl_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    localparam int RUN_W       = 8;
    localparam int LEN_W       = 7;
    localparam int GAP_W       = 8;
    localparam int FLOOR_W     = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [RUN_W-1:0] RUN_SAT   = RUN_W'(250);
    localparam logic [LEN_W-1:0] LEN_CLAMP = LEN_W'(127);

    localparam logic [GAP_W-1:0]   GAP_RESET   = GAP_W'(60);
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(8);

    localparam logic [CFG_IDX_W-1:0] REG_GAP_THRESHOLD   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RUN_COUNT_FLOOR = CFG_IDX_W'(1);

    // One stored run: level in the top bit, clamped length below.
    typedef struct packed {
        logic             level;
        logic [LEN_W-1:0] length;
    } run_entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        run_entry_t        data;
    } store_wr_t;

    typedef struct packed {
        logic             push;
        logic [CNT_W-1:0] count;
    } frame_cmd_t;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
    } cmd_head_t;

    typedef struct packed {
        logic busy;
    } back_stat_t;

endpackage

[sv/plfl_front.sv]
// Front part of the frame logger: accepts pin samples, tracks the current run,
// writes finished runs to the store and issues drain commands. Uses plfl_pkg.
module plfl_front import plfl_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_pin_level,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  stall,
    output store_wr_t             store_wr,
    output frame_cmd_t            frame_cmd
);

    logic [GAP_W-1:0]   gap_reg,   gap_next;
    logic [FLOOR_W-1:0] floor_reg, floor_next;
    logic [RUN_W-1:0]   run_reg,   run_next;
    logic               level_reg, level_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;

    logic             accept;
    logic [RUN_W-1:0] run_inc;
    logic [LEN_W-1:0] len_clamped;
    logic             frame_end;

    assign s_ready   = !stall;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    assign run_inc     = (run_reg < RUN_SAT) ? run_reg + RUN_W'(1) : run_reg;
    assign len_clamped = (run_reg > RUN_W'(LEN_CLAMP)) ? LEN_CLAMP : run_reg[LEN_W-1:0];
    assign frame_end   = (s_pin_level == level_reg) && !level_reg
                         && (run_inc > gap_reg)
                         && (32'(cnt_reg) > 32'(floor_reg));

    always_comb begin
        gap_next   = gap_reg;
        floor_next = floor_reg;
        run_next   = run_reg;
        level_next = level_reg;
        cnt_next   = cnt_reg;
        store_wr   = '{we: 1'b0, addr: cnt_reg[ADDR_W-1:0],
                       data: '{level: level_reg, length: len_clamped}};
        frame_cmd  = '{push: 1'b0, count: cnt_reg};

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_GAP_THRESHOLD:   gap_next   = cfg_data[GAP_W-1:0];
                REG_RUN_COUNT_FLOOR: floor_next = cfg_data[FLOOR_W-1:0];
                default: ;
            endcase
        end

        if (accept) begin
            if (s_pin_level != level_reg) begin
                // Level change: log the finished run while there is room.
                if (32'(cnt_reg) < STORE_DEPTH) begin
                    store_wr.we = 1'b1;
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
                level_next = s_pin_level;
                run_next   = RUN_W'(1);
            end else if (frame_end) begin
                frame_cmd.push = 1'b1;
                cnt_next       = '0;
                run_next       = '0;
            end else begin
                run_next = run_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg   <= GAP_RESET;
            floor_reg <= FLOOR_RESET;
            run_reg   <= '0;
            level_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            gap_reg   <= gap_next;
            floor_reg <= floor_next;
            run_reg   <= run_next;
            level_reg <= level_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[sv/plfl_cmd_q.sv]
// Two-entry queue of drain commands between the front and back parts of the
// frame logger. Uses plfl_pkg.
module plfl_cmd_q import plfl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  frame_cmd_t frame_cmd,
    input  logic       pop,
    output cmd_head_t  head
);

    logic [CNT_W-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg,   fill_next;
    logic             do_push, do_pop;

    assign do_pop  = pop && (fill_reg != 2'd0);
    assign do_push = frame_cmd.push && ((fill_reg != 2'd2) || do_pop);

    assign head.valid = (fill_reg != 2'd0);
    assign head.count = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= frame_cmd.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[sv/plfl_back.sv]
// Back part of the frame logger: owns the run store, drains a frame one entry per
// cycle while m_ready is high, through a registered read and a two-entry output buffer. Uses plfl_pkg.
module plfl_back import plfl_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  store_wr_t        store_wr,
    input  cmd_head_t        head,
    output logic             pop,
    output back_stat_t       stat,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_run_level,
    output logic [LEN_W-1:0] m_run_length,
    output logic             m_last_run
);

    typedef struct packed {
        run_entry_t entry;
        logic       last;
    } result_t;

    run_entry_t       store_mem [STORE_DEPTH];
    run_entry_t       rd_data_reg;
    logic             rd_pend_reg, rd_pend_next;
    logic             rd_last_reg;

    logic             active_reg, active_next;
    logic [CNT_W-1:0] idx_reg,    idx_next;
    logic [CNT_W-1:0] n_reg,      n_next;
    logic [1:0]       occ_reg,    occ_next;

    result_t          buf_reg [2];
    logic             bwr_reg, bwr_next;
    logic             brd_reg, brd_next;
    logic [1:0]       bfill_reg, bfill_next;

    logic issue, out_pop, issue_last;

    assign m_valid      = (bfill_reg != 2'd0);
    assign m_run_level  = buf_reg[brd_reg].entry.level;
    assign m_run_length = buf_reg[brd_reg].entry.length;
    assign m_last_run   = buf_reg[brd_reg].last;
    assign out_pop      = m_valid && m_ready;

    assign pop        = head.valid && !active_reg;
    assign issue      = active_reg && ((occ_reg < 2'd2) || out_pop);
    assign issue_last = (idx_reg + CNT_W'(1)) == n_reg;
    assign stat.busy  = active_reg || (occ_reg != 2'd0);

    always_comb begin
        active_next  = active_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        if (pop) begin
            active_next = 1'b1;
            idx_next    = '0;
            n_next      = head.count;
        end else if (issue) begin
            idx_next = idx_reg + CNT_W'(1);
            if (issue_last) begin
                active_next = 1'b0;
            end
        end
        rd_pend_next = issue;
        occ_next     = occ_reg + 2'(issue) - 2'(out_pop);
        bwr_next     = rd_pend_reg ? !bwr_reg : bwr_reg;
        brd_next     = out_pop ? !brd_reg : brd_reg;
        bfill_next   = bfill_reg + 2'(rd_pend_reg) - 2'(out_pop);
    end

    always_ff @(posedge aclk) begin
        if (store_wr.we) begin
            store_mem[store_wr.addr] <= store_wr.data;
        end
        if (issue) begin
            rd_data_reg <= store_mem[idx_reg[ADDR_W-1:0]];
            rd_last_reg <= issue_last;
        end
        if (rd_pend_reg) begin
            buf_reg[bwr_reg] <= '{entry: rd_data_reg, last: rd_last_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            idx_reg     <= '0;
            n_reg       <= '0;
            occ_reg     <= 2'd0;
            rd_pend_reg <= 1'b0;
            bwr_reg     <= 1'b0;
            brd_reg     <= 1'b0;
            bfill_reg   <= 2'd0;
        end else begin
            active_reg  <= active_next;
            idx_reg     <= idx_next;
            n_reg       <= n_next;
            occ_reg     <= occ_next;
            rd_pend_reg <= rd_pend_next;
            bwr_reg     <= bwr_next;
            brd_reg     <= brd_next;
            bfill_reg   <= bfill_next;
        end
    end

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= 2'd2)
        else $error("reads in flight exceed output buffer room");

    a_occ_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg == bfill_reg + 2'(rd_pend_reg))
        else $error("in-flight count out of step with buffer fill");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (idx_reg < n_reg))
        else $error("drain index ran past frame length");

    a_no_write_while_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.busy |-> !store_wr.we)
        else $error("store written while a frame drains");

    a_last_ends_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && issue_last) |=> !active_reg)
        else $error("drain continued past the last run");

endmodule

[sv/pulse_run_length_frame_logger_core.sv]
// Top level of the pulse run-length frame logger: ties the front tracker,
// the drain command queue and the back drain unit. Uses plfl_pkg.
//
// Usage:
//   s_ channel: one sampled receiver pin level per item (s_pin_level).
//   m_ channel: logged runs of a finished frame, in order (level, length
//   clamped to 127), m_last_run set on the final run of the frame.
//   cfg channel: cfg_index 0 writes gap_threshold, 1 writes run_count_floor;
//   cfg_ready is always high. Write only while the block is idle.
// Timing:
//   A sample that does not end a frame leaves s_ready high; the next sample is
//   taken in the following cycle. A sample that ends a frame starts a drain:
//   its command passes the queue to the drain unit, each run is read from the
//   store into a register and then into the output buffer, and the runs follow
//   one per cycle while m_ready is high, set by the single read port of the run
//   store. s_ready stays low until the whole frame has been delivered.
// Reset (aresetn, synchronous, active low) clears the run tracker, the stored
//   count, the queue and the drain unit and restores the register defaults;
//   the store contents are not cleared and need no clearing pass.
// Receiver stall: the drain pauses with at most two runs buffered or in
//   flight and resumes when m_ready returns; nothing is dropped.
module pulse_run_length_frame_logger_core import plfl_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_pin_level,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_run_level,
    output logic [LEN_W-1:0]      m_run_length,
    output logic                  m_last_run,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    store_wr_t  store_wr;
    frame_cmd_t frame_cmd;
    cmd_head_t  head;
    back_stat_t stat;
    logic       cmd_pop;
    logic       front_stall;

    // Hold new samples while a frame is queued or still draining.
    assign front_stall = head.valid || stat.busy;

    plfl_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pin_level (s_pin_level),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .stall       (front_stall),
        .store_wr    (store_wr),
        .frame_cmd   (frame_cmd)
    );

    plfl_cmd_q u_cmd_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .frame_cmd (frame_cmd),
        .pop       (cmd_pop),
        .head      (head)
    );

    plfl_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .store_wr     (store_wr),
        .head         (head),
        .pop          (cmd_pop),
        .stat         (stat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_run_level  (m_run_level),
        .m_run_length (m_run_length),
        .m_last_run   (m_last_run)
    );

endmodule
